// ===== rtl/core/mcfe_pkg.sv =====
package mcfe_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int VTX_W        = $clog2(MAX_VERTICES);
    localparam int MAX_EDGES    = 256;
    localparam int ARC_SLOTS    = 2 * MAX_EDGES;
    localparam int ARC_W        = $clog2(ARC_SLOTS);
    localparam int ARC_PTR_W    = ARC_W + 1;
    localparam int CNT_W        = VTX_W + 1;

    localparam logic [ARC_PTR_W-1:0] ARC_NONE = ARC_PTR_W'(ARC_SLOTS);
    localparam logic [CNT_W-1:0]     VTX_NONE = CNT_W'(MAX_VERTICES);

    localparam int CAP_W  = 31;
    localparam int RES_W  = 32;
    localparam int COST_W = 16;
    localparam int ACOST_W = COST_W + 1;
    localparam int DIST_W = 32;
    localparam int SUM_W  = 62;
    localparam int PROD_W = RES_W + ACOST_W + 1;

    typedef enum logic [1:0] {
        REQ_ADD   = 2'd0,
        REQ_SOLVE = 2'd1,
        REQ_CLEAR = 2'd2,
        REQ_NONE  = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        REG_SOURCE = 2'd0,
        REG_SINK   = 2'd1,
        REG_VCOUNT = 2'd2,
        REG_UNUSED = 2'd3
    } t_reg_idx;

    typedef enum logic [1:0] {
        MARK_NEW    = 2'd0,
        MARK_QUEUED = 2'd1,
        MARK_DONE   = 2'd2,
        MARK_SPARE  = 2'd3
    } t_mark;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_ADD_RD0,
        ST_ADD_WR0,
        ST_ADD_RD1,
        ST_ADD_WR1,
        ST_PRE,
        ST_PRE_B,
        ST_PRE_SUM,
        ST_PRE_ZERO,
        ST_START,
        ST_INIT,
        ST_SEED,
        ST_POP,
        ST_POP_W,
        ST_VLOAD,
        ST_ARC,
        ST_ARC_W,
        ST_RELAX,
        ST_CHK,
        ST_CHK_W,
        ST_BN,
        ST_BN_W,
        ST_BN_R,
        ST_UP,
        ST_UP_W,
        ST_UP_R,
        ST_UP_M,
        ST_UP_MW,
        ST_DONE
    } t_state;

endpackage

// ===== rtl/core/min_cost_flow_engine_unit.sv =====
// min-cost max-flow engine, successive shortest paths over arc tables in synchronous rams
// add edge: ADD_RD0, ADD_WR0, ADD_RD1, ADD_WR1; clear and unknown stay idle; no result for these
// solve: data dependent; zeroes the flow on every arc pair, then per augmentation resets the
// labels, scans popped vertices, walks and updates the path; every step is one ram read
// one item at a time; a finished result waits in the output register while the next beat enters
// synchronous active-low reset clears control, config to defaults and the list heads to null
module min_cost_flow_engine_unit
    import mcfe_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // request channel
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [1:0]           i_req_type,
    input  logic [5:0]           i_from_vertex,
    input  logic [5:0]           i_to_vertex,
    input  logic [CAP_W-1:0]     i_edge_capacity,
    input  logic [COST_W-1:0]    i_edge_cost,
    // result channel
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [SUM_W-1:0]     o_total_cost,
    output logic                 o_status_code,
    // register port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [3:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    // arc table word: target, cost, next pointer
    localparam int ARCW_W = VTX_W + ACOST_W + ARC_PTR_W;

    t_state n_state, r_state;

    // configuration
    logic [5:0] r_src, r_snk;
    logic [6:0] r_vcnt;

    // graph bookkeeping
    logic [ARC_PTR_W-1:0] r_arcs_used, n_arcs_used;
    logic                 r_ovf, n_ovf;
    logic [MAX_VERTICES-1:0] r_first_vld;

    // latched request
    logic [5:0]        r_from, r_to;
    logic [CAP_W-1:0]  r_cap;
    logic [COST_W-1:0] r_ecost;

    // walk registers
    logic [ARC_PTR_W-1:0] r_a, n_a;
    logic [ARC_W-1:0]     r_acur, n_acur;
    logic [CNT_W-1:0]     r_v, n_v;
    logic [CNT_W-1:0]     r_i, n_i;
    logic [CNT_W-1:0]     r_steps, n_steps;
    logic [DIST_W-1:0]    r_dv, n_dv;
    logic [DIST_W-1:0]    r_nd, n_nd;
    logic [VTX_W-1:0]     r_tgt, n_tgt;
    logic [ARC_W-1:0]     r_pa, n_pa;
    logic [CNT_W-1:0]     r_pv, n_pv;
    logic [RES_W-1:0]     r_flow, n_flow;
    logic [RES_W-1:0]     r_res_a, n_res_a;
    logic [PROD_W-1:0]    r_prod, n_prod;
    logic [SUM_W-1:0]     r_sum, n_sum;

    // deque pointers
    logic [VTX_W-1:0] r_head, n_head, r_tail, n_tail;
    logic [CNT_W-1:0] r_fill, n_fill;

    // output register
    logic             r_out_vld, n_out_vld;
    logic [SUM_W-1:0] r_out_cost, n_out_cost;
    logic             r_out_stat, n_out_stat;

    // memories
    logic [ARCW_W-1:0]    mem_arc   [ARC_SLOTS];
    logic [RES_W-1:0]     mem_res   [ARC_SLOTS];
    logic [ARC_PTR_W-1:0] mem_first [MAX_VERTICES];
    logic [DIST_W-1:0]    mem_dist  [MAX_VERTICES];
    logic [CNT_W-1:0]     mem_pv    [MAX_VERTICES];
    logic [ARC_W-1:0]     mem_pa    [MAX_VERTICES];
    logic [1:0]           mem_mark  [MAX_VERTICES];
    logic [VTX_W-1:0]     mem_dq    [MAX_VERTICES];

    logic [ARCW_W-1:0]    m_arc_rd;
    logic [RES_W-1:0]     m_res_rd;
    logic [ARC_PTR_W-1:0] m_first_rd;
    logic                 r_first_rd_vld;
    logic [DIST_W-1:0]    m_dist_rd;
    logic [CNT_W-1:0]     m_pv_rd;
    logic [ARC_W-1:0]     m_pa_rd;
    logic [1:0]           m_mark_rd;
    logic [VTX_W-1:0]     m_dq_rd;

    // memory controls
    logic                 arc_we;
    logic [ARC_W-1:0]     arc_wa, arc_ra;
    logic [ARCW_W-1:0]    arc_wd;
    logic                 res_we;
    logic [ARC_W-1:0]     res_wa, res_ra;
    logic [RES_W-1:0]     res_wd;
    logic                 first_we;
    logic [VTX_W-1:0]     first_wa, first_ra;
    logic [ARC_PTR_W-1:0] first_wd;
    logic                 vtx_we;      // prev vertex and prev arc pair
    logic                 dist_we;
    logic [VTX_W-1:0]     vtx_wa, vtx_ra;
    logic [DIST_W-1:0]    dist_wd;
    logic [CNT_W-1:0]     pv_wd;
    logic [ARC_W-1:0]     pa_wd;
    logic                 mark_we;
    logic [VTX_W-1:0]     mark_wa, mark_ra;
    logic [1:0]           mark_wd;
    logic                 dq_we;
    logic [VTX_W-1:0]     dq_wa;
    logic [VTX_W-1:0]     dq_wd;
    logic                 first_clr;

    // decoded fields of the arc word
    logic [VTX_W-1:0]     arc_tgt;
    logic [ACOST_W-1:0]   arc_cost;
    logic [ARC_PTR_W-1:0] arc_next;
    assign arc_tgt  = m_arc_rd[ARCW_W-1 -: VTX_W];
    assign arc_cost = m_arc_rd[ARC_PTR_W +: ACOST_W];
    assign arc_next = m_arc_rd[ARC_PTR_W-1:0];

    logic in_acc, cfg_wr;
    logic [CNT_W-1:0] n_eff;
    logic [DIST_W-1:0] nd_calc;
    logic relax_new, relax_better;
    logic bn_go;

    assign o_in_stall = (r_state != ST_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign cfg_wr     = psel && penable && pwrite && pready;
    assign pready     = 1'b1;

    // effective vertex count, capped at the table size
    assign n_eff = (r_vcnt > 7'(MAX_VERTICES)) ? VTX_NONE : CNT_W'(r_vcnt);

    assign nd_calc = r_dv + {{(DIST_W-ACOST_W){arc_cost[ACOST_W-1]}}, arc_cost};
    assign relax_new    = (m_mark_rd == MARK_NEW);
    assign relax_better = ($signed(m_dist_rd) > $signed(r_nd));
    assign bn_go = (r_v != {1'b0, r_src}) && (r_v < n_eff) && (r_steps < n_eff);

    // register read back
    always_comb begin
        case (t_reg_idx'(paddr[3:2]))
            REG_SOURCE: prdata = {26'd0, r_src};
            REG_SINK:   prdata = {26'd0, r_snk};
            REG_VCOUNT: prdata = {25'd0, r_vcnt};
            default:    prdata = 32'd0;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    case (t_req'(i_req_type))
                        REQ_ADD: begin
                            if (r_arcs_used <= ARC_NONE - ARC_PTR_W'(2)) n_state = ST_ADD_RD0;
                        end
                        REQ_SOLVE: n_state = ST_PRE;
                        default:   n_state = ST_IDLE;
                    endcase
                end
            end
            ST_ADD_RD0: n_state = ST_ADD_WR0;
            ST_ADD_WR0: n_state = ST_ADD_RD1;
            ST_ADD_RD1: n_state = ST_ADD_WR1;
            ST_ADD_WR1: n_state = ST_IDLE;
            ST_PRE:     n_state = (r_a + ARC_PTR_W'(1) < r_arcs_used) ? ST_PRE_B : ST_START;
            ST_PRE_B:   n_state = ST_PRE_SUM;
            ST_PRE_SUM: n_state = ST_PRE_ZERO;
            ST_PRE_ZERO: n_state = ST_PRE;
            ST_START: begin
                if ({1'b0, r_src} >= n_eff || {1'b0, r_snk} >= n_eff || r_src == r_snk)
                    n_state = ST_DONE;
                else
                    n_state = ST_INIT;
            end
            ST_INIT:    n_state = (r_i < n_eff) ? ST_INIT : ST_SEED;
            ST_SEED:    n_state = ST_POP;
            ST_POP:     n_state = (r_fill == '0) ? ST_CHK : ST_POP_W;
            ST_POP_W:   n_state = ST_VLOAD;
            ST_VLOAD:   n_state = ST_ARC;
            ST_ARC:     n_state = r_a[ARC_PTR_W-1] ? ST_POP : ST_ARC_W;
            ST_ARC_W: begin
                if (m_res_rd == '0 || {1'b0, arc_tgt} >= n_eff) n_state = ST_ARC;
                else n_state = ST_RELAX;
            end
            ST_RELAX:   n_state = ST_ARC;
            ST_CHK:     n_state = ST_CHK_W;
            ST_CHK_W:   n_state = (m_mark_rd != MARK_NEW) ? ST_BN : ST_DONE;
            ST_BN: begin
                if (bn_go) n_state = ST_BN_W;
                else if (r_v != {1'b0, r_src} || r_flow == '0) n_state = ST_DONE;
                else n_state = ST_UP;
            end
            ST_BN_W:    n_state = ST_BN_R;
            ST_BN_R:    n_state = ST_BN;
            ST_UP:      n_state = (r_v == {1'b0, r_src}) ? ST_INIT : ST_UP_W;
            ST_UP_W:    n_state = ST_UP_R;
            ST_UP_R:    n_state = ST_UP_M;
            ST_UP_M:    n_state = ST_UP_MW;
            ST_UP_MW:   n_state = ST_UP;
            ST_DONE:    n_state = (!r_out_vld || !i_out_stall) ? ST_IDLE : ST_DONE;
            default:    n_state = ST_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        n_arcs_used = r_arcs_used;
        n_ovf       = r_ovf;
        n_a         = r_a;
        n_acur      = r_acur;
        n_v         = r_v;
        n_i         = r_i;
        n_steps     = r_steps;
        n_dv        = r_dv;
        n_nd        = r_nd;
        n_tgt       = r_tgt;
        n_pa        = r_pa;
        n_pv        = r_pv;
        n_flow      = r_flow;
        n_res_a     = r_res_a;
        n_prod      = r_prod;
        n_sum       = r_sum;
        n_head      = r_head;
        n_tail      = r_tail;
        n_fill      = r_fill;
        n_out_vld   = r_out_vld;
        n_out_cost  = r_out_cost;
        n_out_stat  = r_out_stat;

        arc_we = 1'b0;  arc_wa = '0;  arc_wd = '0;  arc_ra = r_a[ARC_W-1:0];
        res_we = 1'b0;  res_wa = '0;  res_wd = '0;  res_ra = r_a[ARC_W-1:0];
        first_we = 1'b0; first_wa = '0; first_wd = '0; first_ra = r_from;
        first_clr = 1'b0;
        vtx_we = 1'b0;  dist_we = 1'b0; vtx_wa = '0; vtx_ra = r_v[VTX_W-1:0];
        dist_wd = '0;   pv_wd = '0;     pa_wd = '0;
        mark_we = 1'b0; mark_wa = '0;   mark_wd = '0; mark_ra = r_snk;
        dq_we = 1'b0;   dq_wa = '0;     dq_wd = '0;

        if (r_out_vld && !i_out_stall) n_out_vld = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    case (t_req'(i_req_type))
                        REQ_ADD: begin
                            if (r_arcs_used > ARC_NONE - ARC_PTR_W'(2)) n_ovf = 1'b1;
                        end
                        REQ_SOLVE: n_a = '0;
                        REQ_CLEAR: begin
                            first_clr   = 1'b1;
                            n_arcs_used = '0;
                            n_ovf       = 1'b0;
                        end
                        default: ;
                    endcase
                end
            end
            ST_ADD_RD0: first_ra = r_from;
            ST_ADD_WR0: begin
                arc_we   = 1'b1;
                arc_wa   = r_arcs_used[ARC_W-1:0];
                arc_wd   = {r_to, {1'b0, r_ecost},
                            r_first_rd_vld ? m_first_rd : ARC_NONE};
                res_we   = 1'b1;
                res_wa   = r_arcs_used[ARC_W-1:0];
                res_wd   = {1'b0, r_cap};
                first_we = 1'b1;
                first_wa = r_from;
                first_wd = r_arcs_used;
            end
            ST_ADD_RD1: first_ra = r_to;
            ST_ADD_WR1: begin
                arc_we   = 1'b1;
                arc_wa   = r_arcs_used[ARC_W-1:0] | ARC_W'(1);
                arc_wd   = {r_from, ACOST_W'(-$signed({1'b0, r_ecost})),
                            r_first_rd_vld ? m_first_rd : ARC_NONE};
                res_we   = 1'b1;
                res_wa   = r_arcs_used[ARC_W-1:0] | ARC_W'(1);
                res_wd   = '0;
                first_we = 1'b1;
                first_wa = r_to;
                first_wd = r_arcs_used | ARC_PTR_W'(1);
                n_arcs_used = r_arcs_used + ARC_PTR_W'(2);
            end
            // return every arc pair to zero flow
            ST_PRE:   res_ra = r_a[ARC_W-1:0];
            ST_PRE_B: begin
                n_res_a = m_res_rd;
                res_ra  = r_a[ARC_W-1:0] | ARC_W'(1);
            end
            ST_PRE_SUM: begin
                res_we = 1'b1;
                res_wa = r_a[ARC_W-1:0];
                res_wd = r_res_a + m_res_rd;
            end
            ST_PRE_ZERO: begin
                res_we = 1'b1;
                res_wa = r_a[ARC_W-1:0] | ARC_W'(1);
                res_wd = '0;
                n_a    = r_a + ARC_PTR_W'(2);
            end
            ST_START: begin
                n_sum = '0;
                n_i   = '0;
            end
            // fresh labels for every vertex in use
            ST_INIT: begin
                if (r_i < n_eff) begin
                    vtx_we  = 1'b1;
                    dist_we = 1'b1;
                    vtx_wa  = r_i[VTX_W-1:0];
                    dist_wd = '0;
                    pv_wd   = VTX_NONE;
                    pa_wd   = '0;
                    mark_we = 1'b1;
                    mark_wa = r_i[VTX_W-1:0];
                    mark_wd = MARK_NEW;
                    n_i     = r_i + CNT_W'(1);
                end
            end
            ST_SEED: begin
                mark_we = 1'b1;
                mark_wa = r_src;
                mark_wd = MARK_QUEUED;
                dq_we   = 1'b1;
                dq_wa   = '0;
                dq_wd   = r_src;
                n_head  = '0;
                n_tail  = VTX_W'(1);
                n_fill  = CNT_W'(1);
            end
            ST_POP: begin
                if (r_fill != '0) begin
                    n_head = r_head + VTX_W'(1);
                    n_fill = r_fill - CNT_W'(1);
                end
            end
            ST_POP_W: begin
                n_v      = {1'b0, m_dq_rd};
                mark_we  = 1'b1;
                mark_wa  = m_dq_rd;
                mark_wd  = MARK_DONE;
                first_ra = m_dq_rd;
                vtx_ra   = m_dq_rd;
            end
            ST_VLOAD: begin
                n_a  = r_first_rd_vld ? m_first_rd : ARC_NONE;
                n_dv = m_dist_rd;
            end
            ST_ARC: begin
                arc_ra = r_a[ARC_W-1:0];
                res_ra = r_a[ARC_W-1:0];
                n_acur = r_a[ARC_W-1:0];
            end
            ST_ARC_W: begin
                n_a     = arc_next;
                n_tgt   = arc_tgt;
                n_nd    = nd_calc;
                mark_ra = arc_tgt;
                vtx_ra  = arc_tgt;
            end
            ST_RELAX: begin
                if (relax_new || relax_better) begin
                    vtx_we  = 1'b1;
                    dist_we = 1'b1;
                    vtx_wa  = r_tgt;
                    dist_wd = r_nd;
                    pv_wd   = r_v;
                    pa_wd   = r_acur;
                    if (r_tgt == r_v[VTX_W-1:0]) n_dv = r_nd;
                end
                if (relax_new) begin
                    mark_we = 1'b1;
                    mark_wa = r_tgt;
                    mark_wd = MARK_QUEUED;
                    if (r_fill < VTX_NONE) begin
                        dq_we  = 1'b1;
                        dq_wa  = r_tail;
                        dq_wd  = r_tgt;
                        n_tail = r_tail + VTX_W'(1);
                        n_fill = r_fill + CNT_W'(1);
                    end
                end else if (relax_better && m_mark_rd == MARK_DONE) begin
                    mark_we = 1'b1;
                    mark_wa = r_tgt;
                    mark_wd = MARK_QUEUED;
                    if (r_fill < VTX_NONE) begin
                        dq_we  = 1'b1;
                        dq_wa  = r_head - VTX_W'(1);
                        dq_wd  = r_tgt;
                        n_head = r_head - VTX_W'(1);
                        n_fill = r_fill + CNT_W'(1);
                    end
                end
            end
            ST_CHK: mark_ra = r_snk;
            ST_CHK_W: begin
                n_v     = {1'b0, r_snk};
                n_steps = '0;
                n_flow  = '1;
            end
            // bottleneck walk from the sink back
            ST_BN: begin
                vtx_ra = r_v[VTX_W-1:0];
                if (!bn_go) n_v = {1'b0, r_snk};
            end
            ST_BN_W: begin
                n_pv   = m_pv_rd;
                res_ra = m_pa_rd;
            end
            ST_BN_R: begin
                if (m_res_rd < r_flow) n_flow = m_res_rd;
                n_v     = r_pv;
                n_steps = r_steps + CNT_W'(1);
            end
            // push the flow along the path
            ST_UP: begin
                vtx_ra = r_v[VTX_W-1:0];
                n_i    = '0;
            end
            ST_UP_W: begin
                n_pa   = m_pa_rd;
                n_pv   = m_pv_rd;
                res_ra = m_pa_rd;
                arc_ra = m_pa_rd;
            end
            ST_UP_R: begin
                res_we = 1'b1;
                res_wa = r_pa;
                res_wd = m_res_rd - r_flow;
                n_prod = PROD_W'($signed({1'b0, r_flow}) * $signed(arc_cost));
                n_v    = r_pv;
            end
            ST_UP_M: res_ra = r_pa ^ ARC_W'(1);
            ST_UP_MW: begin
                res_we = 1'b1;
                res_wa = r_pa ^ ARC_W'(1);
                res_wd = m_res_rd + r_flow;
                n_sum  = r_sum + {{(SUM_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
            end
            ST_DONE: begin
                if (!r_out_vld || !i_out_stall) begin
                    n_out_vld  = 1'b1;
                    n_out_cost = r_sum;
                    n_out_stat = r_ovf;
                end
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_src       <= '0;
            r_snk       <= 6'd63;
            r_vcnt      <= 7'd64;
            r_arcs_used <= '0;
            r_ovf       <= 1'b0;
            r_first_vld <= '0;
            r_head      <= '0;
            r_tail      <= '0;
            r_fill      <= '0;
            r_sum       <= '0;
            r_out_vld   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_arcs_used <= n_arcs_used;
            r_ovf       <= n_ovf;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_fill      <= n_fill;
            r_sum       <= n_sum;
            r_out_vld   <= n_out_vld;
            if (first_clr) r_first_vld <= '0;
            else if (first_we) r_first_vld[first_wa] <= 1'b1;
            if (cfg_wr) begin
                case (t_reg_idx'(paddr[3:2]))
                    REG_SOURCE: r_src  <= pwdata[5:0];
                    REG_SINK:   r_snk  <= pwdata[5:0];
                    REG_VCOUNT: r_vcnt <= pwdata[6:0];
                    default: ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_from  <= i_from_vertex;
            r_to    <= i_to_vertex;
            r_cap   <= i_edge_capacity;
            r_ecost <= i_edge_cost;
        end
        r_a        <= n_a;
        r_acur     <= n_acur;
        r_v        <= n_v;
        r_i        <= n_i;
        r_steps    <= n_steps;
        r_dv       <= n_dv;
        r_nd       <= n_nd;
        r_tgt      <= n_tgt;
        r_pa       <= n_pa;
        r_pv       <= n_pv;
        r_flow     <= n_flow;
        r_res_a    <= n_res_a;
        r_prod     <= n_prod;
        r_out_cost <= n_out_cost;
        r_out_stat <= n_out_stat;
    end

    // arc tables
    always_ff @(posedge i_clk) begin
        if (arc_we) mem_arc[arc_wa] <= arc_wd;
        m_arc_rd <= mem_arc[arc_ra];
    end

    always_ff @(posedge i_clk) begin
        if (res_we) mem_res[res_wa] <= res_wd;
        m_res_rd <= mem_res[res_ra];
    end

    // list heads, null unless the valid bit is set
    always_ff @(posedge i_clk) begin
        if (first_we) mem_first[first_wa] <= first_wd;
        m_first_rd     <= mem_first[first_ra];
        r_first_rd_vld <= r_first_vld[first_ra];
    end

    // search labels
    always_ff @(posedge i_clk) begin
        if (dist_we) mem_dist[vtx_wa] <= dist_wd;
        m_dist_rd <= mem_dist[vtx_ra];
    end

    always_ff @(posedge i_clk) begin
        if (vtx_we) begin
            mem_pv[vtx_wa] <= pv_wd;
            mem_pa[vtx_wa] <= pa_wd;
        end
        m_pv_rd <= mem_pv[vtx_ra];
        m_pa_rd <= mem_pa[vtx_ra];
    end

    always_ff @(posedge i_clk) begin
        if (mark_we) mem_mark[mark_wa] <= mark_wd;
        m_mark_rd <= mem_mark[mark_ra];
    end

    // pending deque
    always_ff @(posedge i_clk) begin
        if (dq_we) mem_dq[dq_wa] <= dq_wd;
        m_dq_rd <= mem_dq[r_head];
    end

    assign o_out_valid   = r_out_vld;
    assign o_total_cost  = r_out_cost;
    assign o_status_code = r_out_stat;

endmodule

// ===== verif/tb_min_cost_flow_engine_unit.sv =====
`timescale 1ns / 100ps

module tb_min_cost_flow_engine_unit;
    import mcfe_pkg::*;

    // ------------------------------------------------------------------
    // flow solver model: arc tables, successive shortest paths
    // ------------------------------------------------------------------
    class flow_scoreboard;
        logic [5:0]        arc_head [ARC_SLOTS];
        logic [31:0]       arc_room [ARC_SLOTS];
        int                arc_price [ARC_SLOTS];
        int                arc_twin [ARC_SLOTS];
        int                arc_link [ARC_SLOTS];
        int                first_arc [MAX_VERTICES];
        int                used_arcs;
        bit                dropped;
        int                src_reg, snk_reg, count_reg;
        logic [SUM_W-1:0]  cost_due [$];
        bit                flag_due [$];
        int                errors;
        int                results_seen;
        int                solves_seen;

        function new();
            errors = 0;
            results_seen = 0;
            solves_seen = 0;
            src_reg = 0;
            snk_reg = 63;
            count_reg = 64;
            wipe();
        endfunction

        function void wipe();
            for (int i = 0; i < MAX_VERTICES; i++) first_arc[i] = ARC_SLOTS;
            used_arcs = 0;
            dropped = 0;
        endfunction

        function void set_reg(t_reg_idx idx, int value);
            case (idx)
                REG_SOURCE: src_reg = value & 63;
                REG_SINK:   snk_reg = value & 63;
                REG_VCOUNT: count_reg = value & 127;
                default: ;
            endcase
        endfunction

        function void store_edge(int from, int to, int cap, int price);
            int a;
            if (used_arcs + 2 > ARC_SLOTS) begin
                dropped = 1;
                return;
            end
            a = used_arcs;
            arc_head[a] = to;
            arc_room[a] = cap;
            arc_price[a] = price;
            arc_twin[a] = a + 1;
            arc_link[a] = first_arc[from];
            first_arc[from] = a;
            arc_head[a+1] = from;
            arc_room[a+1] = 0;
            arc_price[a+1] = -price;
            arc_twin[a+1] = a;
            arc_link[a+1] = first_arc[to];
            first_arc[to] = a + 1;
            used_arcs += 2;
        endfunction

        // d'esopo-pape label correcting search, same visiting order as hardware
        function automatic bit find_path(int n, int src, int snk,
                                         ref int pv[MAX_VERTICES], ref int pa[MAX_VERTICES]);
            longint reach [MAX_VERTICES];
            t_mark  mark [MAX_VERTICES];
            int     ring [MAX_VERTICES];
            int     hd, tl, fill, v, t;
            longint nd;
            for (int i = 0; i < n; i++) begin
                mark[i] = MARK_NEW;
                pv[i] = MAX_VERTICES;
                reach[i] = 0;
            end
            hd = 0; tl = 0; fill = 0;
            mark[src] = MARK_QUEUED;
            ring[tl] = src; tl = (tl + 1) % MAX_VERTICES; fill++;
            while (fill > 0) begin
                v = ring[hd]; hd = (hd + 1) % MAX_VERTICES; fill--;
                mark[v] = MARK_DONE;
                for (int a = first_arc[v]; a < ARC_SLOTS; a = arc_link[a]) begin
                    if (arc_room[a] == 0) continue;
                    t = arc_head[a];
                    if (t >= n) continue;
                    nd = reach[v] + arc_price[a];
                    if (mark[t] == MARK_NEW) begin
                        mark[t] = MARK_QUEUED;
                        reach[t] = nd; pv[t] = v; pa[t] = a;
                        if (fill < MAX_VERTICES) begin
                            ring[tl] = t; tl = (tl + 1) % MAX_VERTICES; fill++;
                        end
                    end else if (reach[t] > nd) begin
                        reach[t] = nd; pv[t] = v; pa[t] = a;
                        if (mark[t] == MARK_DONE) begin
                            mark[t] = MARK_QUEUED;
                            if (fill < MAX_VERTICES) begin
                                hd = (hd + MAX_VERTICES - 1) % MAX_VERTICES;
                                ring[hd] = t; fill++;
                            end
                        end
                    end
                end
            end
            return mark[snk] != MARK_NEW;
        endfunction

        function automatic logic [SUM_W-1:0] min_cost();
            int pv [MAX_VERTICES];
            int pa [MAX_VERTICES];
            int n, v, steps;
            logic [31:0] push;
            logic [63:0] total;
            total = 0;
            // start over from zero flow on every pair
            for (int a = 0; a + 1 < used_arcs; a += 2) begin
                arc_room[a] += arc_room[a+1];
                arc_room[a+1] = 0;
            end
            n = count_reg < MAX_VERTICES ? count_reg : MAX_VERTICES;
            if (src_reg >= n || snk_reg >= n || src_reg == snk_reg) return '0;
            while (find_path(n, src_reg, snk_reg, pv, pa)) begin
                v = snk_reg; steps = 0; push = '1;
                while (v != src_reg && v < n && steps < n) begin
                    if (arc_room[pa[v]] < push) push = arc_room[pa[v]];
                    v = pv[v]; steps++;
                end
                if (v != src_reg || push == 0) break;
                v = snk_reg;
                while (v != src_reg) begin
                    arc_room[pa[v]] -= push;
                    arc_room[arc_twin[pa[v]]] += push;
                    total += 64'(push) * 64'(longint'(arc_price[pa[v]]));
                    v = pv[v];
                end
            end
            return total[SUM_W-1:0];
        endfunction

        function void note_request(t_req kind, int from, int to, int cap, int price);
            case (kind)
                REQ_ADD:   store_edge(from & 63, to & 63, cap & 32'h7fffffff,
                                      price & 16'hffff);
                REQ_SOLVE: begin
                    cost_due.insert(cost_due.size(), min_cost());
                    flag_due.insert(flag_due.size(), dropped);
                    solves_seen++;
                end
                REQ_CLEAR: wipe();
                default: ;
            endcase
        endfunction

        function void check_result(logic [SUM_W-1:0] cost, logic flag);
            logic [SUM_W-1:0] want_cost;
            bit want_flag;
            results_seen++;
            if (cost_due.size() == 0) begin
                $display("%0t: unexpected result cost=%0d status=%0d", $time, cost, flag);
                errors++;
                return;
            end
            want_cost = cost_due[0];
            cost_due.delete(0);
            want_flag = flag_due[0];
            flag_due.delete(0);
            if (cost !== want_cost) begin
                $display("%0t: total_cost expected %0d actual %0d", $time, want_cost, cost);
                errors++;
            end
            if (flag !== want_flag) begin
                $display("%0t: status_code expected %0d actual %0d", $time, want_flag, flag);
                errors++;
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    logic [1:0]         i_req_type;
    logic [5:0]         i_from_vertex;
    logic [5:0]         i_to_vertex;
    logic [CAP_W-1:0]   i_edge_capacity;
    logic [COST_W-1:0]  i_edge_cost;
    logic               o_out_valid;
    logic               i_out_stall;
    logic [SUM_W-1:0]   o_total_cost;
    logic               o_status_code;
    logic               psel, penable, pwrite;
    logic [3:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    flow_scoreboard sb;
    int stall_mode;     // receiver stall pattern selector
    int stall_phase;

    min_cost_flow_engine_unit uut (.*);

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2000ms;
        $display("TB_ERROR");
        $finish;
    end

    // result side: check each accepted beat, stall on a shifting pattern
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall)
                sb.check_result(o_total_cost, o_status_code);
            stall_phase <= stall_phase + 1;
            case (stall_mode)
                0: i_out_stall <= 1'b0;
                1: i_out_stall <= ($urandom_range(0, 3) == 0);
                2: i_out_stall <= (stall_phase % 7) < 3;
                default: i_out_stall <= ($urandom_range(0, 1) == 0);
            endcase
        end
    end

    // register write through setup and access cycles
    task automatic write_reg(t_reg_idx idx, int value);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= 4'(4 * idx); pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        sb.set_reg(idx, value);
    endtask

    // one request beat, held until the block takes it
    task automatic send_req(t_req kind, int from, int to, int cap, int price);
        i_in_valid <= 1'b1;
        i_req_type <= kind;
        i_from_vertex <= 6'(from);
        i_to_vertex <= 6'(to);
        i_edge_capacity <= CAP_W'(cap);
        i_edge_cost <= COST_W'(price);
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_request(kind, from, to, cap, price);
    endtask

    // gap between bursts; sometimes leaves valid low for a random stretch
    task automatic pause_sender();
        int gap;
        gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            i_req_type <= 2'($urandom);
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // wait for all results, then let a trailing add or clear drain
    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.cost_due.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic random_edge(int span, int cap_mode);
        int cap, price;
        case (cap_mode)
            0: cap = $urandom_range(0, 20);
            1: cap = $urandom & 32'h7fffffff;
            default: cap = $urandom_range(1, 1000);
        endcase
        price = ($urandom_range(0, 5) == 0) ? ($urandom & 16'hffff) : $urandom_range(0, 50);
        send_req(REQ_ADD, $urandom_range(0, span - 1), $urandom_range(0, span - 1), cap, price);
    endtask

    initial begin
        int items, burst, span, kind;
        sb = new();
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_req_type = REQ_NONE;
        i_from_vertex = '0; i_to_vertex = '0;
        i_edge_capacity = '0; i_edge_cost = '0;
        i_out_stall = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
        paddr = '0; pwdata = '0;
        stall_mode = 0; stall_phase = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: defaults, extremes of fields, every request kind
        send_req(REQ_SOLVE, 0, 0, 0, 0);                       // empty graph at reset
        send_req(REQ_ADD, 0, 63, 32'h7fffffff, 16'hffff);      // widest capacity and cost
        send_req(REQ_ADD, 0, 63, 5, 0);
        send_req(REQ_SOLVE, 0, 0, 0, 0);
        send_req(REQ_SOLVE, 0, 0, 0, 0);                       // repeat gives same optimum
        send_req(REQ_NONE, 63, 63, 32'h7fffffff, 16'hffff);    // unknown kind ignored
        send_req(REQ_CLEAR, 0, 0, 0, 0);
        send_req(REQ_ADD, 0, 1, 10, 3);
        send_req(REQ_ADD, 1, 63, 4, 2);
        send_req(REQ_ADD, 0, 2, 7, 1);
        send_req(REQ_ADD, 2, 1, 7, 0);
        send_req(REQ_ADD, 5, 5, 9, 9);                         // self loop
        send_req(REQ_ADD, 1, 63, 0, 1);                        // zero capacity
        send_req(REQ_SOLVE, 0, 0, 0, 0);
        drain();
        write_reg(REG_VCOUNT, 0);                              // count below range
        send_req(REQ_SOLVE, 0, 0, 0, 0);
        drain();
        write_reg(REG_VCOUNT, 127);                            // count past the table
        write_reg(REG_SINK, 0);                                // source equals sink
        send_req(REQ_SOLVE, 0, 0, 0, 0);
        drain();
        write_reg(REG_SINK, 63);
        write_reg(REG_SOURCE, 63);
        write_reg(REG_VCOUNT, 63);                             // source out of use
        send_req(REQ_SOLVE, 0, 0, 0, 0);
        drain();
        // table full: overflow then clear
        write_reg(REG_SOURCE, 0);
        write_reg(REG_SINK, 3);
        write_reg(REG_VCOUNT, 4);
        send_req(REQ_CLEAR, 0, 0, 0, 0);
        for (int i = 0; i < MAX_EDGES + 2; i++) begin
            send_req(REQ_ADD, i % 3, (i % 3) + 1, 1 + (i % 5), i % 4);
            if (i % 40 == 0) pause_sender();
        end
        send_req(REQ_SOLVE, 0, 0, 0, 0);
        send_req(REQ_CLEAR, 0, 0, 0, 0);
        send_req(REQ_SOLVE, 0, 0, 0, 0);
        drain();

        // random phases: small graphs mostly, new settings each phase
        items = 0;
        while (items < 1270) begin
            int sel;
            sel = $urandom_range(0, 9);
            span = (sel == 0) ? 64 : (sel < 3 ? 2 : $urandom_range(3, 12));
            stall_mode = $urandom_range(0, 3);
            write_reg(REG_SOURCE, $urandom_range(0, 2) == 0 ? $urandom_range(0, 63) :
                                  $urandom_range(0, span - 1));
            write_reg(REG_SINK, $urandom_range(0, 5) == 0 ? $urandom_range(0, 63) :
                                $urandom_range(0, span - 1));
            write_reg(REG_VCOUNT, $urandom_range(0, 7) == 0 ? $urandom_range(0, 127) : span);
            send_req(REQ_CLEAR, 0, 0, 0, 0);
            items++;
            kind = $urandom_range(0, 2);
            repeat ($urandom_range(3, (span == 64) ? 120 : 30)) begin
                burst = $urandom_range(1, 8);
                repeat (burst) begin
                    sel = $urandom_range(0, 19);
                    if (sel == 0) send_req(REQ_SOLVE, $urandom, $urandom, $urandom, $urandom);
                    else if (sel == 1) send_req(REQ_NONE, $urandom, $urandom, $urandom,
                                                $urandom);
                    else if (sel == 2 && $urandom_range(0, 3) == 0)
                        send_req(REQ_CLEAR, $urandom, $urandom, $urandom, $urandom);
                    else random_edge(span, kind);
                    items++;
                end
                pause_sender();
            end
            send_req(REQ_SOLVE, 0, 0, 0, 0);
            items++;
            drain();
        end

        repeat (50) @(posedge i_clk);
        $display("run covered %0d solves and %0d result beats, %0d random request beats",
                 sb.solves_seen, sb.results_seen, items);
        $display("left over expectations: %0d", sb.cost_due.size());
        if (sb.errors == 0 && sb.cost_due.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
